[sv/qrs_pkg.sv]
package qrs_pkg;

    // root bits from the square root unit, quotient bits from each divider
    localparam int SQRT_STEPS = 34;
    localparam int QUO_BITS   = 32;

    typedef logic [1:0] status_t;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_A_ZERO   = 2'd1;
    localparam status_t ST_NEG_DISC = 2'd2;
    localparam status_t ST_SAT      = 2'd3;

    // per-item control and operands that ride along the pipeline
    typedef struct packed {
        logic               valid;
        logic               a_zero;
        logic               neg_disc;
        logic               a_neg;
        logic signed [31:0] b;
        logic [32:0]        dvsr;
    } side_t;

endpackage

[sv/qrs_disc.sv]
module qrs_disc
    import qrs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] coef_a,
    input  logic signed [31:0] coef_b,
    input  logic signed [31:0] coef_c,
    output side_t              side_out,
    output logic [65:0]        disc
);

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] mag_c;

    logic [63:0] bb_reg;
    logic [63:0] ac_reg;
    logic        add_reg;
    side_t       side1_reg;
    side_t       side1_next;

    logic [65:0] four_ac;
    logic [65:0] bb_ext;
    side_t       side2_next;
    side_t       side2_reg;
    logic [65:0] disc_next;
    logic [65:0] disc_reg;

    assign mag_a = coef_a[31] ? 32'(-coef_a) : 32'(coef_a);
    assign mag_b = coef_b[31] ? 32'(-coef_b) : 32'(coef_b);
    assign mag_c = coef_c[31] ? 32'(-coef_c) : 32'(coef_c);

    // stage one: the two products and the sign of 4ac
    always_comb begin
        side1_next          = '0;
        side1_next.valid    = in_valid;
        side1_next.a_zero   = (coef_a == 32'sd0);
        side1_next.neg_disc = 1'b0;
        side1_next.a_neg    = coef_a[31];
        side1_next.b        = coef_b;
        side1_next.dvsr     = {mag_a, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
        end else if (en) begin
            side1_reg <= side1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb_reg  <= 64'(mag_b) * 64'(mag_b);
            ac_reg  <= 64'(mag_a) * 64'(mag_c);
            add_reg <= (coef_a[31] != coef_c[31]) && (coef_c != 32'sd0);
        end
    end

    // stage two: b*b - 4ac at full width
    assign four_ac = {ac_reg, 2'b00};
    assign bb_ext  = {2'b00, bb_reg};

    always_comb begin
        side2_next = side1_reg;
        disc_next  = '0;
        if (add_reg) begin
            disc_next = bb_ext + four_ac;
        end else if (four_ac > bb_ext) begin
            side2_next.neg_disc = 1'b1;
        end else begin
            disc_next = bb_ext - four_ac;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg <= '0;
        end else if (en) begin
            side2_reg <= side2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            disc_reg <= disc_next;
        end
    end

    assign side_out = side2_reg;
    assign disc     = disc_reg;

endmodule

[sv/qrs_sqrt.sv]
module qrs_sqrt
    import qrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  side_t       side_in,
    input  logic [65:0] rad,
    output side_t       side_out,
    output logic [33:0] root
);

    side_t       side_reg [1:SQRT_STEPS];
    logic [33:0] root_reg [1:SQRT_STEPS];
    logic [36:0] rem_reg  [1:SQRT_STEPS-1];
    logic [67:0] rad_reg  [1:SQRT_STEPS-1];

    // one root bit per stage, restoring digit recurrence
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
        side_t       side_i;
        logic [33:0] root_i;
        logic [36:0] rem_i;
        logic [67:0] rad_i;
        logic [36:0] rem_sh;
        logic [36:0] trial;
        logic        ge;

        if (i == 0) begin : g_first
            assign side_i = side_in;
            assign root_i = '0;
            assign rem_i  = '0;
            assign rad_i  = {2'b00, rad};
        end else begin : g_rest
            assign side_i = side_reg[i];
            assign root_i = root_reg[i];
            assign rem_i  = rem_reg[i];
            assign rad_i  = rad_reg[i];
        end

        assign rem_sh = {rem_i[34:0], rad_i[67:66]};
        assign trial  = {1'b0, root_i, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[i+1] <= '0;
            end else if (en) begin
                side_reg[i+1] <= side_i;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i+1] <= {root_i[32:0], ge};
            end
        end

        if (i < SQRT_STEPS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i+1] <= ge ? (rem_sh - trial) : rem_sh;
                    rad_reg[i+1] <= {rad_i[65:0], 2'b00};
                end
            end
        end
    end

    assign side_out = side_reg[SQRT_STEPS];
    assign root     = root_reg[SQRT_STEPS];

endmodule

[sv/qrs_div.sv]
module qrs_div
    import qrs_pkg::*;
(
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] numer,
    input  logic [32:0] dvsr,
    output logic [31:0] quo,
    output logic        quo_high
);

    logic [32:0] rem_reg  [1:QUO_BITS];
    logic [31:0] lo_reg   [1:QUO_BITS];
    logic [31:0] quo_reg  [1:QUO_BITS];
    logic [32:0] dvsr_reg [1:QUO_BITS];
    logic        high_reg [1:QUO_BITS];

    // one quotient bit per stage; quotients of 2^32 and up only raise the flag
    for (genvar i = 0; i < QUO_BITS; i++) begin : g_step
        logic [32:0] rem_i;
        logic [31:0] lo_i;
        logic [31:0] quo_i;
        logic [32:0] dvsr_i;
        logic        high_i;
        logic [33:0] rem_sh;
        logic        ge;

        if (i == 0) begin : g_first
            assign rem_i  = {1'b0, numer[63:32]};
            assign lo_i   = numer[31:0];
            assign quo_i  = '0;
            assign dvsr_i = dvsr;
            assign high_i = ({1'b0, numer[63:32]} >= dvsr);
        end else begin : g_rest
            assign rem_i  = rem_reg[i];
            assign lo_i   = lo_reg[i];
            assign quo_i  = quo_reg[i];
            assign dvsr_i = dvsr_reg[i];
            assign high_i = high_reg[i];
        end

        assign rem_sh = {rem_i, lo_i[31]};
        assign ge     = (rem_sh >= {1'b0, dvsr_i});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= ge ? 33'(rem_sh - {1'b0, dvsr_i}) : rem_sh[32:0];
                lo_reg[i+1]   <= {lo_i[30:0], 1'b0};
                quo_reg[i+1]  <= {quo_i[30:0], ge};
                dvsr_reg[i+1] <= dvsr_i;
                high_reg[i+1] <= high_i;
            end
        end
    end

    assign quo      = quo_reg[QUO_BITS];
    assign quo_high = high_reg[QUO_BITS];

endmodule

[sv/quadratic_root_solver.sv]
// Real roots of a*x^2 + b*x + c in signed fixed point with FRAC_BITS fraction
// bits. The discriminant is formed exactly, its floor square root is taken,
// and both roots (-b +/- root)/(2a) are truncated toward zero and saturated to
// 32 bits. One coefficient set is accepted every cycle unless the result side
// stalls. The pipeline has 2 stages for the products and the discriminant,
// 34 for the bit-per-stage square root, 1 for the numerators, 32 for the two
// bit-per-stage dividers and 1 for saturation and status.
// A stall at the result side holds the whole pipeline in place.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_coef_a,
    input  logic signed [31:0] s_coef_b,
    input  logic signed [31:0] s_coef_c,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_root_plus,
    output logic signed [31:0] m_root_minus,
    output logic [1:0]         m_status
);

    logic        en;
    side_t       side_disc;
    logic [65:0] disc;
    side_t       side_sqrt;
    logic [33:0] root;

    logic signed [35:0] neg_b;
    logic signed [35:0] num_p;
    logic signed [35:0] num_m;
    logic [35:0]        mag_p;
    logic [35:0]        mag_m;

    side_t       side_n_reg;
    logic [63:0] numer_p_reg;
    logic [63:0] numer_m_reg;
    logic        neg_p_reg;
    logic        neg_m_reg;

    side_t       side_d_reg  [1:QUO_BITS];
    logic        neg_p_d_reg [1:QUO_BITS];
    logic        neg_m_d_reg [1:QUO_BITS];

    logic [31:0] quo_p;
    logic [31:0] quo_m;
    logic        high_p;
    logic        high_m;

    logic [31:0] root_p_next;
    logic [31:0] root_m_next;
    logic        sat_p;
    logic        sat_m;
    status_t     status_next;

    logic        valid_reg;
    logic [31:0] root_p_reg;
    logic [31:0] root_m_reg;
    status_t     status_reg;

    // the whole pipeline moves whenever the output slot can take a beat
    assign en      = m_ready || !valid_reg;
    assign s_ready = en;

    qrs_disc u_disc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_valid),
        .coef_a   (s_coef_a),
        .coef_b   (s_coef_b),
        .coef_c   (s_coef_c),
        .side_out (side_disc),
        .disc     (disc)
    );

    qrs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_disc),
        .rad      (disc),
        .side_out (side_sqrt),
        .root     (root)
    );

    // numerators -b + s and -b - s, as magnitudes scaled by the fraction bits
    assign neg_b = -36'(side_sqrt.b);
    assign num_p = neg_b + $signed({2'b00, root});
    assign num_m = neg_b - $signed({2'b00, root});
    assign mag_p = num_p[35] ? 36'(-num_p) : 36'(num_p);
    assign mag_m = num_m[35] ? 36'(-num_m) : 36'(num_m);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_n_reg <= '0;
        end else if (en) begin
            side_n_reg <= side_sqrt;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            numer_p_reg <= 64'(mag_p) << FRAC_BITS;
            numer_m_reg <= 64'(mag_m) << FRAC_BITS;
            neg_p_reg   <= num_p[35] != side_sqrt.a_neg;
            neg_m_reg   <= num_m[35] != side_sqrt.a_neg;
        end
    end

    qrs_div u_div_plus (
        .aclk     (aclk),
        .en       (en),
        .numer    (numer_p_reg),
        .dvsr     (side_n_reg.dvsr),
        .quo      (quo_p),
        .quo_high (high_p)
    );

    qrs_div u_div_minus (
        .aclk     (aclk),
        .en       (en),
        .numer    (numer_m_reg),
        .dvsr     (side_n_reg.dvsr),
        .quo      (quo_m),
        .quo_high (high_m)
    );

    // control and signs follow the dividers stage for stage
    for (genvar i = 1; i <= QUO_BITS; i++) begin : g_side
        side_t src_side;
        logic  src_neg_p;
        logic  src_neg_m;

        if (i == 1) begin : g_first
            assign src_side  = side_n_reg;
            assign src_neg_p = neg_p_reg;
            assign src_neg_m = neg_m_reg;
        end else begin : g_rest
            assign src_side  = side_d_reg[i-1];
            assign src_neg_p = neg_p_d_reg[i-1];
            assign src_neg_m = neg_m_d_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_d_reg[i] <= '0;
            end else if (en) begin
                side_d_reg[i] <= src_side;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                neg_p_d_reg[i] <= src_neg_p;
                neg_m_d_reg[i] <= src_neg_m;
            end
        end
    end

    // saturation of each root and the final status
    always_comb begin
        sat_p       = 1'b0;
        sat_m       = 1'b0;
        root_p_next = quo_p;
        root_m_next = quo_m;

        if (neg_p_d_reg[QUO_BITS]) begin
            if (high_p || (quo_p > 32'h8000_0000)) begin
                sat_p       = 1'b1;
                root_p_next = 32'h8000_0000;
            end else begin
                root_p_next = -quo_p;
            end
        end else if (high_p || quo_p[31]) begin
            sat_p       = 1'b1;
            root_p_next = 32'h7FFF_FFFF;
        end

        if (neg_m_d_reg[QUO_BITS]) begin
            if (high_m || (quo_m > 32'h8000_0000)) begin
                sat_m       = 1'b1;
                root_m_next = 32'h8000_0000;
            end else begin
                root_m_next = -quo_m;
            end
        end else if (high_m || quo_m[31]) begin
            sat_m       = 1'b1;
            root_m_next = 32'h7FFF_FFFF;
        end

        priority if (side_d_reg[QUO_BITS].a_zero) begin
            status_next = ST_A_ZERO;
            root_p_next = '0;
            root_m_next = '0;
        end else if (side_d_reg[QUO_BITS].neg_disc) begin
            status_next = ST_NEG_DISC;
            root_p_next = '0;
            root_m_next = '0;
        end else if (sat_p || sat_m) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= side_d_reg[QUO_BITS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_p_reg <= root_p_next;
            root_m_reg <= root_m_next;
            status_reg <= status_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_root_plus  = $signed(root_p_reg);
    assign m_root_minus = $signed(root_m_reg);
    assign m_status     = status_reg;

endmodule

[test/tb.sv]
module tb;
    import qrs_pkg::*;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } coefs_t;

    typedef struct packed {
        logic signed [31:0] rp;
        logic signed [31:0] rm;
        status_t            st;
    } roots_t;

    localparam int QFRAC      = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int CALM_START = 150;
    localparam int CALM_END   = 450;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_coef_a;
    logic signed [31:0] s_coef_b;
    logic signed [31:0] s_coef_c;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_root_plus;
    logic signed [31:0] m_root_minus;
    logic [1:0]         m_status;

    coefs_t pending_coefs[$];
    roots_t expected_roots[$];
    int     cycles;
    int     mismatches;
    int     roots_checked;
    int     status_seen[4];

    quadratic_root_solver DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_coef_a(s_coef_a), .s_coef_b(s_coef_b), .s_coef_c(s_coef_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_root_plus(m_root_plus), .m_root_minus(m_root_minus), .m_status(m_status)
    );

    // one root: (num << QFRAC) / (2a), truncated toward zero, saturated
    function automatic logic signed [31:0] divide_root(logic signed [127:0] num,
                                                       logic signed [31:0] a,
                                                       ref bit sat);
        logic [127:0] q;
        logic [127:0] mag_num;
        logic [127:0] mag_a;
        bit           neg;
        mag_num = num < 0 ? -num : num;
        mag_a   = a < 0 ? -128'sd1 * a : a;
        q       = (mag_num << QFRAC) / (2 * mag_a);
        neg     = (num < 0) != (a < 0);
        if (neg) begin
            if (q > 128'h8000_0000) begin
                sat = 1;
                return 32'sh8000_0000;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF) begin
            sat = 1;
            return 32'sh7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // expected roots and status for one coefficient set
    function automatic roots_t solve_quadratic(coefs_t k);
        logic signed [127:0] disc;
        logic [127:0]        root;
        logic [127:0]        cand;
        bit                  sat;
        roots_t              r;
        r   = '0;
        sat = 0;
        if (k.a == 0) begin
            r.st = ST_A_ZERO;
            return r;
        end
        disc = 128'(k.b) * 128'(k.b) - 128'sd4 * 128'(k.a) * 128'(k.c);
        if (disc < 0) begin
            r.st = ST_NEG_DISC;
            return r;
        end
        root = 0;
        for (int i = 33; i >= 0; i--) begin
            cand = root | (128'd1 << i);
            if (cand * cand <= disc) root = cand;
        end
        r.rp = divide_root(-128'(k.b) + $signed(root), k.a, sat);
        r.rm = divide_root(-128'(k.b) - $signed(root), k.a, sat);
        r.st = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    function automatic logic signed [31:0] rand_small();
        return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    endfunction

    // clock
    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // cycle count and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // driver: feeds pending coefficient sets with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            if (pending_coefs.size() > 0 &&
                ((cycles >= CALM_START && cycles < CALM_END) ||
                 $urandom_range(0, 99) >= 11)) begin
                coefs_t k;
                k = pending_coefs.pop_front();
                s_valid  <= 1;
                s_coef_a <= k.a;
                s_coef_b <= k.b;
                s_coef_c <= k.c;
            end else begin
                s_valid <= 0;
            end
        end
    end

    // monitor: predict on input beats, check on result beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            m_ready <= (cycles >= CALM_START && cycles < CALM_END) ||
                       $urandom_range(0, 99) >= 11;
            if (m_valid && m_ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected beat", m_status, 0);
                end else begin
                    roots_t e;
                    e = expected_roots.pop_front();
                    if (m_root_plus !== e.rp) report_mismatch("root_plus", m_root_plus, e.rp);
                    if (m_root_minus !== e.rm) report_mismatch("root_minus", m_root_minus, e.rm);
                    if (m_status !== e.st) report_mismatch("status", m_status, e.st);
                    status_seen[e.st]++;
                    roots_checked++;
                end
            end
            if (s_valid && s_ready)
                expected_roots.push_back(solve_quadratic({s_coef_a, s_coef_b, s_coef_c}));
        end
    end

    initial begin
        coefs_t k;
        int     kind;
        aresetn = 0;

        // directed: zero a, negative discriminant, saturation, extremes
        pending_coefs.push_back({32'sh0, 32'sh0001_0000, 32'sh0001_0000});
        pending_coefs.push_back({32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF});
        pending_coefs.push_back({32'sh0001_0000, 32'sh0, 32'sh0001_0000});
        pending_coefs.push_back({32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000});
        pending_coefs.push_back({32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000});
        pending_coefs.push_back({-32'sh0001_0000, 32'sh0, 32'sh0004_0000});
        pending_coefs.push_back({32'sh0001_0000, 32'sh0, 32'sh0});
        pending_coefs.push_back({32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh0});
        pending_coefs.push_back({32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000});
        pending_coefs.push_back({32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        pending_coefs.push_back({32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
        pending_coefs.push_back({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
        pending_coefs.push_back({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        pending_coefs.push_back({-32'sh0000_0001, 32'sh0, -32'sh0000_0001});
        pending_coefs.push_back({-32'sh0000_0001, 32'sh0, 32'sh7FFF_FFFF});
        pending_coefs.push_back({32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF});
        pending_coefs.push_back({32'sh0000_0002, 32'sh0000_0005, 32'sh0000_0003});

        // random: small real-rooted sets, full-range noise, tiny a with random b, zero a, small sets
        for (int i = 0; i < 700; i++) begin
            kind = $urandom_range(0, 99);
            k.a = rand_small();
            k.b = rand_small();
            k.c = rand_small();
            if (kind < 35) begin
                if ((k.a < 0) == (k.c < 0)) k.c = -k.c;
            end else if (kind < 70) begin
                k.a = $urandom;
                k.b = $urandom;
                k.c = $urandom;
            end else if (kind < 80) begin
                k.a = $signed($urandom_range(0, 64)) - 32;
                k.b = $urandom;
            end else if (kind < 86) begin
                k.a = 0;
                k.b = $urandom;
                k.c = $urandom;
            end
            if (k.a == 0 && kind < 80) k.a = 32'sh0001_0000;
            pending_coefs.push_back(k);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1;

        wait (pending_coefs.size() == 0 && !s_valid && expected_roots.size() == 0);
        repeat (100) @(posedge aclk);

        $display("checked %0d root pairs: %0d ok, %0d zero a, %0d no real roots, %0d saturated",
                 roots_checked, status_seen[ST_OK], status_seen[ST_A_ZERO],
                 status_seen[ST_NEG_DISC], status_seen[ST_SAT]);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
sv/qrs_pkg.sv
sv/qrs_disc.sv
sv/qrs_sqrt.sv
sv/qrs_div.sv
sv/quadratic_root_solver.sv
test/tb.sv
